[hw/rtl/mfp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message fragment packetizer package
// Shared types and constants for the byte framing datapath.
// ----------------------------------------------------------------------------
package mfp_pkg;

  // The payload size must be a power of two, so that the fragment index and
  // the position inside a fragment are plain bit fields of the byte offset.
  localparam int unsigned PayloadBytes = 1024;
  localparam int unsigned PayloadBits  = $clog2(PayloadBytes);
  localparam int unsigned PsizeW       = $clog2(PayloadBytes + 1);

  localparam int unsigned LenW     = 28;
  localparam int unsigned OffW     = 27;
  localparam int unsigned FragCntW = LenW - PayloadBits;

  localparam logic [LenW-1:0] MaxLength    = LenW'(134217728);
  localparam logic [LenW-1:0] PayloadLen   = LenW'(PayloadBytes);
  localparam logic [15:0]     MaxFragments = 16'hffff;

  localparam logic [7:0] Magic0 = 8'heb;
  localparam logic [7:0] Magic1 = 8'h90;
  localparam logic [7:0] Tail0  = 8'hcd;
  localparam logic [7:0] Tail1  = 8'hde;

  localparam int unsigned StepW = 5;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic [LenW-1:0] message_length;
    logic [7:0]      channel_id;
  } mfp_in_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       packet_end;
    logic       run_last;
    logic       too_many_fragments;
  } mfp_out_t;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic            hdr;
    logic            tail;
    logic            err;
    logic [15:0]     frag_idx;
    logic [15:0]     frag_cnt;
    logic [15:0]     psize;
    logic [LenW-1:0] total_len;
    logic [7:0]      channel;
  } mfp_desc_t;

endpackage

[hw/rtl/mfp_frame.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message fragment packetizer framing state
// Tracks the message position and builds the framing descriptor of each byte.
// ----------------------------------------------------------------------------
module mfp_frame (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  mfp_pkg::mfp_in_t    in_data_i,
  output logic                in_stall_o,
  output logic                desc_valid_o,
  output mfp_pkg::mfp_desc_t  desc_o,
  input  logic                desc_stall_i
);

  logic                           in_message_q, in_message_d;
  logic [mfp_pkg::OffW-1:0]       offset_q, offset_d;
  logic [mfp_pkg::LenW-1:0]       length_q, length_d;
  logic [7:0]                     channel_q, channel_d;

  logic                           accept;
  logic                           first;
  logic [mfp_pkg::LenW-1:0]       len_fix;
  logic [mfp_pkg::LenW-1:0]       len_cur;
  logic [7:0]                     chan_cur;
  logic [mfp_pkg::OffW-1:0]       off_cur;
  logic [mfp_pkg::PayloadBits-1:0] pos;
  logic [mfp_pkg::LenW-1:0]       base;
  logic [mfp_pkg::LenW-1:0]       rest;
  logic [mfp_pkg::PsizeW-1:0]     psize;
  logic                           closes;
  logic [mfp_pkg::LenW-1:0]       len_round;
  logic [mfp_pkg::FragCntW-1:0]   frags;
  logic                           err;
  logic [mfp_pkg::LenW-1:0]       off_next;

  assign accept       = in_valid_i && !desc_stall_i;
  assign in_stall_o   = desc_stall_i;
  assign desc_valid_o = in_valid_i;

  always_comb begin
    first = !in_message_q;
    if (in_data_i.message_length == '0) begin
      len_fix = mfp_pkg::LenW'(1);
    end else if (in_data_i.message_length > mfp_pkg::MaxLength) begin
      len_fix = mfp_pkg::MaxLength;
    end else begin
      len_fix = in_data_i.message_length;
    end
    len_cur  = first ? len_fix : length_q;
    chan_cur = first ? in_data_i.channel_id : channel_q;
    off_cur  = first ? '0 : offset_q;

    pos  = off_cur[mfp_pkg::PayloadBits-1:0];
    base = {1'b0, off_cur[mfp_pkg::OffW-1:mfp_pkg::PayloadBits],
            {mfp_pkg::PayloadBits{1'b0}}};
    rest = len_cur - base;
    if (rest < mfp_pkg::PayloadLen) begin
      psize = rest[mfp_pkg::PsizeW-1:0];
    end else begin
      psize = mfp_pkg::PsizeW'(mfp_pkg::PayloadBytes);
    end
    closes = ({1'b0, pos} + mfp_pkg::PsizeW'(1)) >= psize;

    len_round = len_cur + mfp_pkg::LenW'(mfp_pkg::PayloadBytes - 1);
    frags     = len_round[mfp_pkg::LenW-1:mfp_pkg::PayloadBits];
    err       = frags > mfp_pkg::FragCntW'(mfp_pkg::MaxFragments);

    desc_o.data_byte = in_data_i.data_byte;
    desc_o.hdr       = !err && (pos == '0);
    desc_o.tail      = !err && closes;
    desc_o.err       = err;
    desc_o.frag_idx  = off_cur[mfp_pkg::PayloadBits +: 16];
    desc_o.frag_cnt  = frags[15:0];
    desc_o.psize     = 16'(psize);
    desc_o.total_len = len_cur;
    desc_o.channel   = chan_cur;

    off_next = {1'b0, off_cur} + mfp_pkg::LenW'(1);

    in_message_d = in_message_q;
    offset_d     = offset_q;
    length_d     = length_q;
    channel_d    = channel_q;
    if (accept) begin
      length_d  = len_cur;
      channel_d = chan_cur;
      if (off_next >= len_cur) begin
        in_message_d = 1'b0;
        offset_d     = '0;
      end else begin
        in_message_d = 1'b1;
        offset_d     = off_next[mfp_pkg::OffW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_message_q <= 1'b0;
      offset_q     <= '0;
      length_q     <= '0;
      channel_q    <= '0;
    end else begin
      in_message_q <= in_message_d;
      offset_q     <= offset_d;
      length_q     <= length_d;
      channel_q    <= channel_d;
    end
  end

endmodule

[hw/rtl/mfp_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message fragment packetizer byte emitter
// Holds one framing descriptor and steps through its header, data and tail
// bytes into the output register, or gives one flagged transfer for an error.
// ----------------------------------------------------------------------------
module mfp_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                desc_valid_i,
  input  mfp_pkg::mfp_desc_t  desc_i,
  output logic                desc_stall_o,
  output logic                out_valid_o,
  output mfp_pkg::mfp_out_t   out_data_o,
  input  logic                out_stall_i
);

  localparam logic [mfp_pkg::StepW-1:0] StepHdrFirst = mfp_pkg::StepW'(0);
  localparam logic [mfp_pkg::StepW-1:0] StepData     = mfp_pkg::StepW'(14);
  localparam logic [mfp_pkg::StepW-1:0] StepTail0    = mfp_pkg::StepW'(15);
  localparam logic [mfp_pkg::StepW-1:0] StepTail1    = mfp_pkg::StepW'(16);

  mfp_pkg::mfp_desc_t              desc_q;
  logic                            item_valid_q;
  logic [mfp_pkg::StepW-1:0]       step_q;
  logic                            out_valid_q;
  mfp_pkg::mfp_out_t               out_q;

  logic                            load_out;
  logic [mfp_pkg::StepW-1:0]       last_step;
  logic                            item_done;
  logic                            take;
  mfp_pkg::mfp_out_t               result;

  assign load_out     = !out_valid_q || !out_stall_i;
  assign last_step    = desc_q.tail ? StepTail1 : StepData;
  assign item_done    = item_valid_q && load_out && (step_q == last_step);
  assign take         = !item_valid_q || item_done;
  assign desc_stall_o = !take;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;

  always_comb begin
    result.packet_byte        = 8'h00;
    result.packet_end         = 1'b0;
    result.run_last           = 1'b0;
    result.too_many_fragments = 1'b0;
    if (desc_q.err) begin
      result.run_last           = 1'b1;
      result.too_many_fragments = 1'b1;
    end else begin
      case (step_q)
        StepHdrFirst:         result.packet_byte = mfp_pkg::Magic0;
        5'd1:                 result.packet_byte = mfp_pkg::Magic1;
        5'd2:                 result.packet_byte = desc_q.frag_idx[7:0];
        5'd3:                 result.packet_byte = desc_q.frag_idx[15:8];
        5'd4:                 result.packet_byte = desc_q.frag_cnt[7:0];
        5'd5:                 result.packet_byte = desc_q.frag_cnt[15:8];
        5'd6:                 result.packet_byte = desc_q.psize[7:0];
        5'd7:                 result.packet_byte = desc_q.psize[15:8];
        5'd8:                 result.packet_byte = desc_q.total_len[7:0];
        5'd9:                 result.packet_byte = desc_q.total_len[15:8];
        5'd10:                result.packet_byte = desc_q.total_len[23:16];
        5'd11:                result.packet_byte = {4'h0, desc_q.total_len[27:24]};
        5'd12:                result.packet_byte = desc_q.channel;
        5'd13:                result.packet_byte = 8'h00;
        StepData: begin
          result.packet_byte = desc_q.data_byte;
          result.run_last    = !desc_q.tail;
        end
        StepTail0:            result.packet_byte = mfp_pkg::Tail0;
        StepTail1: begin
          result.packet_byte = mfp_pkg::Tail1;
          result.packet_end  = 1'b1;
          result.run_last    = 1'b1;
        end
        default:              result.packet_byte = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (desc_valid_i && take) begin
        item_valid_q <= 1'b1;
        step_q       <= desc_i.hdr ? StepHdrFirst : StepData;
      end else if (item_done) begin
        item_valid_q <= 1'b0;
      end else if (item_valid_q && load_out) begin
        step_q <= step_q + mfp_pkg::StepW'(1);
      end
      if (load_out) begin
        out_valid_q <= item_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (desc_valid_i && take) begin
      desc_q <= desc_i;
    end
    if (load_out && item_valid_q) begin
      out_q <= result;
    end
  end

endmodule

[hw/rtl/message_fragment_packetizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message fragment packetizer
// Cuts a byte stream into fragments and frames each one with a 14-byte
// header and a 2-byte tail.
//
//   Channel   Direction  Handshake                Payload
//   input     in         in_valid_i / in_stall_o  mfp_in_t (one message byte)
//   output    out        out_valid_o / out_stall_i mfp_out_t (one packet byte)
//
// The emitter sends, for a message byte that opens a fragment, the header
// bytes and then the byte; for one that closes a fragment, the byte and then
// the tail bytes; for one that does both, all three; and for any other byte,
// the byte alone. The emitter holds a single message byte, so a new input
// transfer is taken only in the cycle the emitter finishes its current byte
// or while it is empty. Reset clears all message tracking and empties the
// emitter and the output register.
// ----------------------------------------------------------------------------
module message_fragment_packetizer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  mfp_pkg::mfp_in_t   in_data_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output mfp_pkg::mfp_out_t  out_data_o,
  input  logic               out_stall_i
);

  logic                desc_valid;
  logic                desc_stall;
  mfp_pkg::mfp_desc_t  desc;

  mfp_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_stall_o   (in_stall_o),
    .desc_valid_o (desc_valid),
    .desc_o       (desc),
    .desc_stall_i (desc_stall)
  );

  mfp_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid),
    .desc_i       (desc),
    .desc_stall_o (desc_stall),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

[tb/sv/packet_stream_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet stream checker
// Watches both channels of the message fragment packetizer. For every message
// byte taken on the input it predicts the framed datagram bytes: the header
// that opens a fragment, the byte itself and the tail that closes a fragment.
// For bytes of an oversized message it predicts the single flagged transfer.
// Each output transfer is compared field by field with the oldest prediction.
// The checker reports how many predictions are still waiting and how many
// mismatches it found.
// ----------------------------------------------------------------------------
module packet_stream_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  mfp_pkg::mfp_in_t           in_data_i,
  input  logic                       in_stall_i,
  input  logic                       out_valid_i,
  input  mfp_pkg::mfp_out_t          out_data_i,
  input  logic                       out_stall_i,
  output int unsigned                pending_o,
  output int unsigned                mismatches_o,
  output int unsigned                checked_o,
  output int unsigned                datagrams_o,
  output int unsigned                rejected_o
);

  localparam int unsigned HeaderLen = 14;

  mfp_pkg::mfp_out_t                framed_bytes_q [$];
  logic [mfp_pkg::LenW-1:0]         msg_length;
  logic [7:0]                       msg_channel;
  logic [mfp_pkg::OffW-1:0]         msg_offset;
  logic                             msg_open;
  int unsigned                      mismatch_count;
  int unsigned                      checked_count;
  int unsigned                      datagram_count;
  int unsigned                      rejected_count;

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("[%0t] output transfer %0d: %s expected %02h, got %02h",
             $time, checked_count, what, want, got);
    mismatch_count++;
  endtask

  task automatic queue_framed_byte(input logic [7:0] value, input logic closes_datagram,
                                   input logic ends_run, input logic rejected);
    mfp_pkg::mfp_out_t framed;
    framed.packet_byte        = value;
    framed.packet_end         = closes_datagram;
    framed.run_last           = ends_run;
    framed.too_many_fragments = rejected;
    framed_bytes_q.insert(framed_bytes_q.size(), framed);
  endtask

  task automatic frame_message_byte(input mfp_pkg::mfp_in_t item);
    logic [mfp_pkg::LenW-1:0] total;
    logic [mfp_pkg::LenW-1:0] frag_count;
    logic [mfp_pkg::LenW-1:0] frag_index;
    logic [mfp_pkg::LenW-1:0] frag_pos;
    logic [mfp_pkg::LenW-1:0] frag_size;
    logic [mfp_pkg::LenW-1:0] remaining;
    logic                     closes;
    logic [7:0]               header [HeaderLen];
    if (!msg_open) begin
      total = item.message_length;
      if (total == '0) total = mfp_pkg::LenW'(1);
      if (total > mfp_pkg::MaxLength) total = mfp_pkg::MaxLength;
      msg_length  = total;
      msg_channel = item.channel_id;
      msg_offset  = '0;
      msg_open    = 1'b1;
    end
    total      = msg_length;
    frag_count = (total + mfp_pkg::PayloadLen - mfp_pkg::LenW'(1)) / mfp_pkg::PayloadLen;
    if (frag_count > mfp_pkg::LenW'(mfp_pkg::MaxFragments)) begin
      queue_framed_byte(8'h00, 1'b0, 1'b1, 1'b1);
    end else begin
      frag_index = mfp_pkg::LenW'(msg_offset) / mfp_pkg::PayloadLen;
      frag_pos   = mfp_pkg::LenW'(msg_offset) % mfp_pkg::PayloadLen;
      remaining  = total - frag_index * mfp_pkg::PayloadLen;
      frag_size  = (remaining < mfp_pkg::PayloadLen) ? remaining : mfp_pkg::PayloadLen;
      closes     = (frag_pos + mfp_pkg::LenW'(1)) >= frag_size;
      if (frag_pos == '0) begin
        header = '{mfp_pkg::Magic0, mfp_pkg::Magic1,
                   frag_index[7:0], frag_index[15:8],
                   frag_count[7:0], frag_count[15:8],
                   frag_size[7:0], frag_size[15:8],
                   total[7:0], total[15:8], total[23:16], 8'(total >> 24),
                   msg_channel, 8'h00};
        for (int i = 0; i < HeaderLen; i++) begin
          queue_framed_byte(header[i], 1'b0, 1'b0, 1'b0);
        end
      end
      queue_framed_byte(item.data_byte, 1'b0, !closes, 1'b0);
      if (closes) begin
        queue_framed_byte(mfp_pkg::Tail0, 1'b0, 1'b0, 1'b0);
        queue_framed_byte(mfp_pkg::Tail1, 1'b1, 1'b1, 1'b0);
      end
    end
    if (mfp_pkg::LenW'(msg_offset) + mfp_pkg::LenW'(1) >= total) begin
      msg_open   = 1'b0;
      msg_offset = '0;
    end else begin
      msg_offset = msg_offset + mfp_pkg::OffW'(1);
    end
  endtask

  always @(posedge clk_i) begin
    mfp_pkg::mfp_out_t want;
    if (!rst_ni) begin
      framed_bytes_q.delete();
      msg_length     = '0;
      msg_channel    = '0;
      msg_offset     = '0;
      msg_open       = 1'b0;
      mismatch_count = 0;
      checked_count  = 0;
      datagram_count = 0;
      rejected_count = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        frame_message_byte(in_data_i);
      end
      if (out_valid_i && !out_stall_i) begin
        checked_count++;
        if (out_data_i.packet_end === 1'b1) datagram_count++;
        if (out_data_i.too_many_fragments === 1'b1) rejected_count++;
        if (framed_bytes_q.size() == 0) begin
          report_mismatch("transfer with nothing predicted, packet_byte", 8'h00,
                          out_data_i.packet_byte);
        end else begin
          want = framed_bytes_q[0];
          framed_bytes_q.delete(0);
          if (out_data_i.packet_byte !== want.packet_byte) begin
            report_mismatch("packet_byte", want.packet_byte, out_data_i.packet_byte);
          end
          if (out_data_i.packet_end !== want.packet_end) begin
            report_mismatch("packet_end", 8'(want.packet_end), 8'(out_data_i.packet_end));
          end
          if (out_data_i.run_last !== want.run_last) begin
            report_mismatch("run_last", 8'(want.run_last), 8'(out_data_i.run_last));
          end
          if (out_data_i.too_many_fragments !== want.too_many_fragments) begin
            report_mismatch("too_many_fragments", 8'(want.too_many_fragments),
                            8'(out_data_i.too_many_fragments));
          end
        end
      end
    end
    pending_o    <= framed_bytes_q.size();
    mismatches_o <= mismatch_count;
    checked_o    <= checked_count;
    datagrams_o  <= datagram_count;
    rejected_o   <= rejected_count;
  end

endmodule

[tb/sv/tb_message_fragment_packetizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message fragment packetizer testbench
// Feeds whole messages into the packetizer: a short directed set with the
// field extremes and the zero length case, then messages of random length and
// content, and last an oversized message whose bytes must all be flagged.
// Both sides insert random gaps, the output side once holds off long enough
// to back up the input, and the sender drains the pipeline between phases.
// The checker instance predicts and compares.
// ----------------------------------------------------------------------------
module tb_message_fragment_packetizer;

  localparam int unsigned LimitCycles   = 1000000;
  localparam int unsigned RandomBytes   = 310;
  localparam int unsigned DrainAt       = 6;
  localparam int unsigned HoldOffAfter  = 300;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned RejectedBytes = 20;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  mfp_pkg::mfp_in_t   in_data;
  logic               in_stall;
  logic               out_valid;
  mfp_pkg::mfp_out_t  out_data;
  logic               out_stall;
  int unsigned        pending;
  int unsigned        mismatches;
  int unsigned        checked;
  int unsigned        datagrams;
  int unsigned        rejected;
  int unsigned        cycle_count;
  int unsigned        messages_sent;
  int unsigned        bytes_sent;
  logic [7:0]         payload_q [$];

  message_fragment_packetizer uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_data_i   (in_data),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_stall_i (out_stall)
  );

  packet_stream_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_data_i    (in_data),
    .in_stall_i   (in_stall),
    .out_valid_i  (out_valid),
    .out_data_i   (out_data),
    .out_stall_i  (out_stall),
    .pending_o    (pending),
    .mismatches_o (mismatches),
    .checked_o    (checked),
    .datagrams_o  (datagrams),
    .rejected_o   (rejected)
  );

  always #5 clk = ~clk;

  task automatic offer_byte(input mfp_pkg::mfp_in_t item, input bit no_gaps);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_message(input logic [mfp_pkg::LenW-1:0] length_field,
                              input logic [7:0] channel, input bit no_gaps);
    mfp_pkg::mfp_in_t item;
    foreach (payload_q[i]) begin
      item.data_byte = payload_q[i];
      if (i == 0) begin
        item.message_length = length_field;
        item.channel_id     = channel;
      end else begin
        item.message_length = mfp_pkg::LenW'($urandom);
        item.channel_id     = 8'($urandom);
      end
      offer_byte(item, no_gaps);
    end
    messages_sent++;
    bytes_sent += payload_q.size();
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < LimitCycles) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned taken;
    int unsigned wait_cycles;
    bit          no_stalls;
    taken     = 0;
    no_stalls = 1'b0;
    out_stall = 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 40 == 0) no_stalls = ($urandom_range(0, 2) == 0);
      if (taken == HoldOffAfter) begin
        wait_cycles = HoldOffCycles;
      end else begin
        wait_cycles = no_stalls ? 0 : $urandom_range(0, 11);
      end
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    int unsigned              random_bytes;
    int unsigned              message_index;
    int unsigned              length;
    int unsigned              pick;
    logic [mfp_pkg::LenW-1:0] length_field;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    messages_sent = 0;
    bytes_sent    = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    payload_q = '{8'h00};
    send_message('0, 8'hff, 1'b0);
    payload_q = '{8'hff};
    send_message(mfp_pkg::LenW'(1), 8'h00, 1'b0);
    payload_q = '{8'haa, 8'h55};
    send_message(mfp_pkg::LenW'(2), 8'h5a, 1'b1);
    payload_q = '{8'h01, 8'h80, 8'h7f, 8'hfe};
    send_message(mfp_pkg::LenW'(4), 8'h81, 1'b0);
    payload_q.delete();
    for (int i = 0; i < 16; i++) payload_q = {payload_q, 8'(i * 17)};
    send_message(mfp_pkg::LenW'(16), 8'h3c, 1'b1);
    wait_for_drain();

    random_bytes  = 0;
    message_index = 0;
    while (random_bytes < RandomBytes) begin
      if (message_index == DrainAt) wait_for_drain();
      pick = $urandom_range(0, 9);
      if (pick < 3) length = $urandom_range(1, 4);
      else if (pick < 9) length = $urandom_range(5, 40);
      else length = $urandom_range(41, 120);
      length_field = mfp_pkg::LenW'(length);
      if (length == 1 && $urandom_range(0, 3) == 0) length_field = '0;
      payload_q.delete();
      repeat (length) payload_q = {payload_q, 8'($urandom)};
      send_message(length_field, 8'($urandom), $urandom_range(0, 3) == 0);
      random_bytes += length;
      message_index++;
    end

    payload_q.delete();
    repeat (RejectedBytes) payload_q = {payload_q, 8'($urandom)};
    send_message({mfp_pkg::LenW{1'b1}}, 8'hc3, 1'b0);
    wait_for_drain();
    repeat (SettleCycles) @(posedge clk);

    $display("Sent %0d message bytes in %0d messages, the last one too long to frame.",
             bytes_sent, messages_sent);
    $display("Checked %0d output transfers: %0d datagrams, %0d flagged bytes, %0d mismatches.",
             checked, datagrams, rejected, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
